>>> sv/aes_pkg.sv
package aes_pkg;

  typedef struct packed {
    logic        op;
    logic [63:0] block_high;
    logic [63:0] block_low;
  } in_item_t;

  typedef struct packed {
    logic [63:0] result_high;
    logic [63:0] result_low;
  } out_item_t;

  localparam int unsigned Rounds   = 14;
  localparam int unsigned CfgWords = 4;
  localparam logic [7:0]  Poly     = 8'h1b;

  typedef enum logic [1:0] {
    REG_KEY_0 = 2'd0,
    REG_KEY_1 = 2'd1,
    REG_KEY_2 = 2'd2,
    REG_KEY_3 = 2'd3
  } reg_index_t;

  localparam logic [7:0] FWD_BOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] INV_BOX [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };

  function automatic logic [7:0] xt(input logic [7:0] v);
    xt = {v[6:0], 1'b0} ^ (v[7] ? Poly : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] t);
    sub_word = {FWD_BOX[t[31:24]], FWD_BOX[t[23:16]], FWD_BOX[t[15:8]], FWD_BOX[t[7:0]]};
  endfunction

  // state byte i sits at bits 127-8i
  function automatic logic [127:0] sub_bytes(input logic [127:0] s, input logic inv);
    logic [127:0] r;
    r = '0;
    for (int i = 0; i < 16; i++) begin
      r[8*i +: 8] = inv ? INV_BOX[s[8*i +: 8]] : FWD_BOX[s[8*i +: 8]];
    end
    return r;
  endfunction

  function automatic logic [127:0] shift_rows(input logic [127:0] s, input logic inv);
    logic [127:0] r;
    r = '0;
    for (int c = 0; c < 4; c++) begin
      for (int rw = 0; rw < 4; rw++) begin
        if (inv) begin
          r[127 - 8*(rw + 4*((c + rw) % 4)) -: 8] = s[127 - 8*(rw + 4*c) -: 8];
        end else begin
          r[127 - 8*(rw + 4*c) -: 8] = s[127 - 8*(rw + 4*((c + rw) % 4)) -: 8];
        end
      end
    end
    return r;
  endfunction

  function automatic logic [31:0] mix_col(input logic [31:0] col, input logic inv);
    logic [7:0] a [4];
    logic [7:0] a2 [4];
    logic [7:0] a4 [4];
    logic [7:0] a8 [4];
    logic [7:0] m [4][4];
    logic [31:0] r;
    r = '0;
    for (int k = 0; k < 4; k++) begin
      a[k]  = col[31 - 8*k -: 8];
      a2[k] = xt(a[k]);
      a4[k] = xt(a2[k]);
      a8[k] = xt(a4[k]);
      m[k][0] = inv ? (a8[k] ^ a4[k] ^ a2[k]) : a2[k];
      m[k][1] = inv ? (a8[k] ^ a2[k] ^ a[k]) : (a2[k] ^ a[k]);
      m[k][2] = inv ? (a8[k] ^ a4[k] ^ a[k]) : a[k];
      m[k][3] = inv ? (a8[k] ^ a[k]) : a[k];
    end
    for (int rw = 0; rw < 4; rw++) begin
      r[31 - 8*rw -: 8] = m[rw][0] ^ m[(rw + 1) % 4][1] ^ m[(rw + 2) % 4][2]
                        ^ m[(rw + 3) % 4][3];
    end
    return r;
  endfunction

  function automatic logic [127:0] mix_columns(input logic [127:0] s, input logic inv);
    logic [127:0] r;
    r = '0;
    for (int c = 0; c < 4; c++) begin
      r[127 - 32*c -: 32] = mix_col(s[127 - 32*c -: 32], inv);
    end
    return r;
  endfunction

endpackage

>>> sv/aes256_block_cipher_unit.sv
// AES-256 ECB engine: one 128-bit block per cycle while in_stall is low, op selects encrypt
// or decrypt per item. The pipeline is one initial key add and 14 round stages; an output
// stall while out_valid is high freezes the whole pipeline. The 60-word round-key schedule
// is built one word per cycle into registers after reset and after every key write: the
// input is stalled while the key is loaded and through the 52 expansion steps.
// Write the key only while the pipeline is empty.
module aes256_block_cipher_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  aes_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output aes_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [63:0]        cfg_data
);
  import aes_pkg::*;

  localparam int unsigned NStage = Rounds + 1;

  logic [63:0]  key_word [CfgWords];
  logic [31:0]  w [60];
  logic [31:0]  w_new;
  logic [5:0]   exp_idx;
  logic [7:0]   rc;
  logic         key_load;
  logic         key_busy;
  logic         key_wait;

  logic         stg_valid [NStage];
  logic         stg_op [NStage];
  logic [127:0] stg_state [NStage];
  logic [127:0] stg_in [NStage];
  logic [127:0] rk_enc [NStage];
  logic [127:0] rk_dec [NStage];
  logic         advance;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CfgWords; i++) key_word[i] <= '0;
      key_load <= 1'b1;
    end else begin
      if (cfg_valid) begin
        unique case (reg_index_t'(cfg_index))
          REG_KEY_0: key_word[0] <= cfg_data;
          REG_KEY_1: key_word[1] <= cfg_data;
          REG_KEY_2: key_word[2] <= cfg_data;
          REG_KEY_3: key_word[3] <= cfg_data;
          default: ;
        endcase
      end
      key_load <= cfg_valid;
    end
  end

  // key schedule: shift register, newest word enters at the top
  always_comb begin
    w_new = w[59];
    if (exp_idx[2:0] == 3'd0) begin
      w_new = sub_word({w[59][23:0], w[59][31:24]}) ^ {rc, 24'h0};
    end else if (exp_idx[2:0] == 3'd4) begin
      w_new = sub_word(w[59]);
    end
    w_new = w_new ^ w[52];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_busy <= 1'b0;
      exp_idx  <= '0;
      rc       <= 8'h01;
    end else if (key_load) begin
      key_busy <= 1'b1;
      exp_idx  <= 6'd8;
      rc       <= 8'h01;
    end else if (key_busy) begin
      if (exp_idx[2:0] == 3'd0) rc <= xt(rc);
      exp_idx <= exp_idx + 6'd1;
      if (exp_idx == 6'd59) key_busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (key_load) begin
      w[52] <= key_word[0][63:32];
      w[53] <= key_word[0][31:0];
      w[54] <= key_word[1][63:32];
      w[55] <= key_word[1][31:0];
      w[56] <= key_word[2][63:32];
      w[57] <= key_word[2][31:0];
      w[58] <= key_word[3][63:32];
      w[59] <= key_word[3][31:0];
    end else if (key_busy) begin
      for (int i = 0; i < 59; i++) w[i] <= w[i+1];
      w[59] <= w_new;
    end
  end

  always_comb begin
    for (int rd = 0; rd < NStage; rd++) begin
      rk_enc[rd] = {w[4*rd], w[4*rd+1], w[4*rd+2], w[4*rd+3]};
      rk_dec[rd] = {w[4*(Rounds-rd)], w[4*(Rounds-rd)+1], w[4*(Rounds-rd)+2],
                    w[4*(Rounds-rd)+3]};
    end
  end

  assign key_wait = key_load || key_busy;
  assign advance  = !(out_valid && out_stall);
  assign in_stall = rst || key_wait || !advance;

  // stage 0 adds the first key; stage k runs round k (encrypt) or an inverse round (decrypt)
  always_comb begin
    stg_in[0] = {in_data.block_high, in_data.block_low}
              ^ (in_data.op ? rk_dec[0] : rk_enc[0]);
    for (int k = 1; k < NStage; k++) begin
      if (!stg_op[k-1]) begin
        stg_in[k] = shift_rows(sub_bytes(stg_state[k-1], 1'b0), 1'b0);
        if (k != Rounds) stg_in[k] = mix_columns(stg_in[k], 1'b0);
        stg_in[k] = stg_in[k] ^ rk_enc[k];
      end else begin
        stg_in[k] = sub_bytes(shift_rows(stg_state[k-1], 1'b1), 1'b1) ^ rk_dec[k];
        if (k != Rounds) stg_in[k] = mix_columns(stg_in[k], 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NStage; k++) stg_valid[k] <= 1'b0;
    end else if (advance) begin
      stg_valid[0] <= in_valid && !key_wait;
      for (int k = 1; k < NStage; k++) stg_valid[k] <= stg_valid[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      stg_op[0]    <= in_data.op;
      stg_state[0] <= stg_in[0];
      for (int k = 1; k < NStage; k++) begin
        stg_op[k]    <= stg_op[k-1];
        stg_state[k] <= stg_in[k];
      end
    end
  end

  assign out_valid            = stg_valid[NStage-1];
  assign out_data.result_high = stg_state[NStage-1][127:64];
  assign out_data.result_low  = stg_state[NStage-1][63:0];

endmodule
